[src/pdec_pkg.sv]
package pdec_pkg;

	// Character codes
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_PERCENT = 8'h25;

	// Most bytes one input beat can produce
	localparam int MAX_RES = 3;
	// Output queue depth
	localparam int Q_DEPTH = 4;

	// Escape tracking, one-hot
	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,  // no escape pending
		PH_PCT  = 3'b010,  // '%' seen
		PH_DIG  = 3'b100   // '%' and one hex digit seen
	} phase_t;

	// Decoded bytes for one input beat
	typedef struct packed {
		logic [MAX_RES-1:0][7:0] chars;
		logic [MAX_RES-1:0]      lasts;
		logic [1:0]              count;
	} pdec_res_t;

	// One queued output beat
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} pdec_beat_t;

	function automatic logic is_hex(input logic [7:0] c);
		is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h37;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h57;
		end
		hex_val = v[3:0];
	endfunction

endpackage

[src/percent_decoder_top.sv]
// Streaming form-urlencoded decoder. Bytes enter one per beat with in_last
// marking the end of a string; '+' leaves as a space, "%hh" as the byte it
// names, and broken escapes leave literally. An input beat is registered,
// decoded combinationally, and its 0 to 3 result bytes are appended to a
// 4-entry output queue that drains one beat per cycle while out_ready is
// high. An accepted byte passes through the input register and the output
// queue before it leaves. With the output side always ready the block
// takes one byte per cycle and never stalls: the escape handling never
// lets the queue hold more than three bytes. The input stalls only when
// output back-pressure fills the queue.
// out_last is set on the final decoded byte of each string.
module percent_decoder_top import pdec_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       out_last
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	phase_t     phase_q;
	logic [7:0] held_q;
	phase_t     phase_nxt;
	logic [7:0] held_nxt;
	pdec_res_t  res;

	pdec_beat_t queue_q [Q_DEPTH];
	pdec_beat_t queue_nxt [Q_DEPTH];
	logic [2:0] cnt_q;
	logic [2:0] cnt_keep;
	logic [2:0] cnt_sum;
	logic       pop;
	logic       fire;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= in_char;
			last_s1 <= in_last;
		end
	end

	// Decode
	pdec_decode u_decode (
		.ch        (char_s1),
		.last      (last_s1),
		.phase     (phase_q),
		.held      (held_q),
		.res       (res),
		.phase_nxt (phase_nxt),
		.held_nxt  (held_nxt)
	);

	// Queue room check
	assign pop      = (cnt_q != 3'd0) && out_ready;
	assign cnt_keep = cnt_q - {2'b00, pop};
	assign cnt_sum  = cnt_keep + {1'b0, res.count};
	assign fire     = valid_s1 && (cnt_sum <= 3'(Q_DEPTH));
	assign in_ready = !valid_s1 || fire;

	// Escape state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= 8'h00;
		end else if (fire) begin
			phase_q <= phase_nxt;
			held_q  <= held_nxt;
		end
	end

	// Queue: shift out head, append new results behind kept entries
	always_comb begin
		logic [2:0] k;
		for (int i = 0; i < Q_DEPTH; i++) begin
			k = 3'(i) - cnt_keep;
			if (3'(i) < cnt_keep) begin
				queue_nxt[i] = (pop && i < Q_DEPTH - 1) ? queue_q[(i + 1) % Q_DEPTH]
					: queue_q[i];
			end else if (fire && k < {1'b0, res.count}) begin
				queue_nxt[i].ch   = res.chars[k[1:0]];
				queue_nxt[i].last = res.lasts[k[1:0]];
			end else begin
				queue_nxt[i] = queue_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < Q_DEPTH; i++) begin
			queue_q[i] <= queue_nxt[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else begin
			cnt_q <= fire ? cnt_sum : cnt_keep;
		end
	end

	// Output beat
	assign out_valid = cnt_q != 3'd0;
	assign out_char  = queue_q[0].ch;
	assign out_last  = queue_q[0].last;

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(Q_DEPTH))
		else $error("output queue overflow");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |=> phase_q == PH_IDLE && held_q == 8'h00)
		else $error("escape state not cleared at end of string");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |-> res.count != 2'd0)
		else $error("end of string produced no byte");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(char_s1) && $stable(last_s1))
		else $error("stalled input register changed");

endmodule

[src/pdec_decode.sv]
module pdec_decode import pdec_pkg::*; (
	input  logic [7:0] ch,
	input  logic       last,
	input  phase_t     phase,
	input  logic [7:0] held,
	output pdec_res_t  res,
	output phase_t     phase_nxt,
	output logic [7:0] held_nxt
);

	logic [1:0] n;
	logic       fresh;

	always_comb begin
		n         = 2'd0;
		fresh     = 1'b1;
		phase_nxt = PH_IDLE;
		held_nxt  = held;
		res       = '0;

		// Resolve a pending escape
		case (phase)
			PH_PCT: begin
				if (is_hex(ch)) begin
					held_nxt  = ch;
					phase_nxt = PH_DIG;
					fresh     = 1'b0;
				end else begin
					res.chars[n] = CH_PERCENT;
					n = n + 2'd1;
				end
			end
			PH_DIG: begin
				if (is_hex(ch)) begin
					res.chars[n] = {hex_val(held), hex_val(ch)};
					n = n + 2'd1;
					fresh = 1'b0;
				end else begin
					res.chars[n] = CH_PERCENT;
					n = n + 2'd1;
					res.chars[n] = held;
					n = n + 2'd1;
				end
			end
			default: begin
			end
		endcase

		// Plain handling of the current byte
		if (fresh) begin
			if (ch == CH_PLUS) begin
				res.chars[n] = CH_SPACE;
				n = n + 2'd1;
			end else if (ch == CH_PERCENT) begin
				phase_nxt = PH_PCT;
			end else begin
				res.chars[n] = ch;
				n = n + 2'd1;
			end
		end

		// End of string: flush and clear
		if (last) begin
			if (phase_nxt == PH_PCT) begin
				res.chars[n] = CH_PERCENT;
				n = n + 2'd1;
			end else if (phase_nxt == PH_DIG) begin
				res.chars[n] = CH_PERCENT;
				n = n + 2'd1;
				res.chars[n] = held_nxt;
				n = n + 2'd1;
			end
			phase_nxt = PH_IDLE;
			held_nxt  = 8'h00;
		end

		res.count = n;
		for (int i = 0; i < MAX_RES; i++) begin
			res.lasts[i] = last && (n != 2'd0) && (2'(i) == n - 2'd1);
		end
	end

endmodule
